// ----- rtl/dcd_pkg.sv -----
`default_nettype none

package dcd_pkg;

    // atan table geometry
    localparam int TAB_SHIFT  = 8;
    localparam int TAB_POINTS = 1 << TAB_SHIFT;
    localparam int IDX_W      = TAB_SHIFT + 1;
    localparam int Q_FRAC     = 23;
    localparam int DIV_STEPS  = 24;

    localparam logic signed [32:0] HALF_PI_Q30 = 33'sd1686629713;
    localparam logic signed [26:0] CLIP_LIMIT  = 27'sd41943040;
    localparam logic [28:0]        ONE_Q23     = 29'd8388608;

    // diode curves, Q.16
    localparam logic signed [32:0] SI_C = 33'sd235930;
    localparam logic signed [32:0] GE_C = 33'sd229376;
    localparam logic signed [32:0] SI_K = 33'sd23265;
    localparam logic signed [32:0] GE_K = 33'sd7537;
    localparam logic signed [32:0] SI_R = 33'sd468;
    localparam logic signed [32:0] GE_R = 33'sd1311;

    localparam longint CORDIC_ANG [0:10] = '{
        843314857, 497837830, 263043837, 133525159, 67021687, 33543515,
        16775851, 8388437, 4194283, 2097149, 1048576
    };

    typedef logic [30:0] atan_tab_t [0:TAB_POINTS];

    // atan(k/TAB_POINTS) in Q1.30 by 30-step integer CORDIC
    function automatic atan_tab_t build_atan_tab();
        atan_tab_t tab;
        longint    x;
        longint    y;
        longint    z;
        longint    ang;
        longint    dx;
        longint    dy;
        for (int k = 0; k <= TAB_POINTS; k++) begin
            x = longint'(TAB_POINTS) <<< 28;
            y = longint'(k) <<< 28;
            z = 0;
            if (k != 0) begin
                for (int i = 0; i < 30; i++) begin
                    ang = (i < 11) ? CORDIC_ANG[i] : (longint'(1) <<< (30 - i));
                    dx  = y >>> i;
                    dy  = x >>> i;
                    if (y > 0) begin
                        x = x + dx;
                        y = y - dy;
                        z = z + ang;
                    end
                    else begin
                        x = x - dx;
                        y = y + dy;
                        z = z - ang;
                    end
                end
            end
            tab[k] = (z < 0) ? 31'd0 : z[30:0];
        end
        return tab;
    endfunction

    localparam atan_tab_t ATAN_TAB = build_atan_tab();

    // register map
    typedef enum logic [2:0] {
        REG_INPUT_HP_COEFF  = 3'd0,
        REG_CAP_LP_COEFF    = 3'd1,
        REG_OUTPUT_LP_COEFF = 3'd2,
        REG_DRIVE_GAIN      = 3'd3,
        REG_OUTPUT_VOLUME   = 3'd4,
        REG_CAP_ENABLE      = 3'd5,
        REG_DIODE_SELECT    = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [17:0] input_hp_coeff;
        logic signed [17:0] cap_lp_coeff;
        logic signed [17:0] output_lp_coeff;
        logic [23:0]        drive_gain;
        logic [23:0]        output_volume;
        logic               cap_enable;
        logic               diode_select;
    } cfg_t;

    typedef enum logic [1:0] {
        STG_HP  = 2'd0,
        STG_CAP = 2'd1,
        STG_OUT = 2'd2
    } stage_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_AP_M1,
        OP_AP_Y,
        OP_AP_M2,
        OP_AP_D,
        OP_DRV_M,
        OP_DRV_S,
        OP_U_M,
        OP_U,
        OP_DIV,
        OP_TAB,
        OP_INT_M,
        OP_INT,
        OP_W_M1,
        OP_W_M2,
        OP_W,
        OP_VOL_M,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t    op;
        stage_t stage;
    } cmd_t;

    typedef struct packed {
        logic inv;
    } status_t;

    // shift right with rounding: add half an LSB, then floor
    function automatic logic signed [66:0] rnd_shr(input logic signed [66:0] v,
                                                   input int sh);
        return (v + (67'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
        if (v > 67'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -67'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [66:0] v);
        if (v > 67'sd8388607)
            return 24'sh7fffff;
        else if (v < -67'sd8388608)
            return 24'sh800000;
        else
            return v[23:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dcd_ifs.sv -----
`default_nettype none

interface dcd_in_if;
    logic               valid;
    logic               ready;
    logic               channel_index;
    logic signed [23:0] sample_in;

    modport source (output valid, output channel_index, output sample_in, input ready);
    modport sink   (input valid, input channel_index, input sample_in, output ready);
endinterface

interface dcd_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/dcd_ctrl.sv -----
`default_nettype none

module dcd_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire logic            cap_enable,
    input  wire dcd_pkg::status_t status,
    output dcd_pkg::cmd_t        cmd
);
    import dcd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_AP_M1, S_AP_Y, S_AP_M2, S_AP_D, S_DRV_M, S_DRV_S, S_U_M, S_U,
        S_DIV, S_TAB, S_INT_M, S_INT, S_W_M1, S_W_M2, S_W, S_VOL_M, S_FIN
    } state_t;

    state_t      state_reg;
    stage_t      stage_reg;
    logic [4:0]  cnt_reg;
    logic        out_valid_reg;
    logic        out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // decode commands from state
    always_comb
    begin
        cmd.stage = stage_reg;
        case (state_reg)
            S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
            S_AP_M1: cmd.op = OP_AP_M1;
            S_AP_Y:  cmd.op = OP_AP_Y;
            S_AP_M2: cmd.op = OP_AP_M2;
            S_AP_D:  cmd.op = OP_AP_D;
            S_DRV_M: cmd.op = OP_DRV_M;
            S_DRV_S: cmd.op = OP_DRV_S;
            S_U_M:   cmd.op = OP_U_M;
            S_U:     cmd.op = OP_U;
            S_DIV:   cmd.op = OP_DIV;
            S_TAB:   cmd.op = OP_TAB;
            S_INT_M: cmd.op = OP_INT_M;
            S_INT:   cmd.op = OP_INT;
            S_W_M1:  cmd.op = OP_W_M1;
            S_W_M2:  cmd.op = OP_W_M2;
            S_W:     cmd.op = OP_W;
            S_VOL_M: cmd.op = OP_VOL_M;
            S_FIN:   cmd.op = out_free ? OP_OUT : OP_NONE;
            default: cmd.op = OP_NONE;
        endcase
    end

    // sequence one request through the chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stage_reg     <= STG_HP;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // raise valid on a finished request, drop it once taken
            if (state_reg == S_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        stage_reg <= STG_HP;
                        state_reg <= S_AP_M1;
                    end
                end
                S_AP_M1: state_reg <= S_AP_Y;
                S_AP_Y:  state_reg <= S_AP_M2;
                S_AP_M2: state_reg <= S_AP_D;
                S_AP_D:
                begin
                    case (stage_reg)
                        STG_HP:
                        begin
                            if (cap_enable)
                            begin
                                stage_reg <= STG_CAP;
                                state_reg <= S_AP_M1;
                            end
                            else
                                state_reg <= S_DRV_M;
                        end
                        STG_CAP: state_reg <= S_DRV_M;
                        default: state_reg <= S_VOL_M;
                    endcase
                end
                S_DRV_M: state_reg <= S_DRV_S;
                S_DRV_S: state_reg <= S_U_M;
                S_U_M:   state_reg <= S_U;
                S_U:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // status is valid from here on; skip division when |u| <= 1
                    if (!status.inv || cnt_reg == 5'(DIV_STEPS - 1))
                        state_reg <= S_TAB;
                    cnt_reg <= cnt_reg + 5'd1;
                end
                S_TAB:   state_reg <= S_INT_M;
                S_INT_M: state_reg <= S_INT;
                S_INT:   state_reg <= S_W_M1;
                S_W_M1:  state_reg <= S_W_M2;
                S_W_M2:  state_reg <= S_W;
                S_W:
                begin
                    stage_reg <= STG_OUT;
                    state_reg <= S_AP_M1;
                end
                S_VOL_M: state_reg <= S_FIN;
                S_FIN:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dcd_datapath.sv -----
`default_nettype none

module dcd_datapath #(
    parameter int CHANNELS = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dcd_pkg::cmd_t      cmd,
    input  wire dcd_pkg::cfg_t      cfg,
    input  wire logic               channel_index,
    input  wire logic signed [23:0] sample_in,
    output dcd_pkg::status_t        status,
    output logic signed [23:0]      sample_out
);
    import dcd_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic signed [31:0] dly_reg [3][CHANNELS];

    logic [CH_W-1:0]    ch_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic signed [26:0] s_reg;
    logic               neg_reg;
    logic               inv_reg;
    logic [28:0]        m_reg;
    logic [28:0]        rem_reg;
    logic [23:0]        nlo_reg;
    logic [23:0]        t_reg;
    logic [30:0]        lo_reg;
    logic signed [32:0] diff_reg;
    logic signed [25:0] a_reg;
    logic signed [65:0] prod_reg;
    logic signed [65:0] acc_reg;
    logic signed [23:0] out_reg;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic               mul_en;
    logic signed [32:0] coef;
    logic signed [31:0] dly;
    logic signed [66:0] prod_rnd;

    logic signed [66:0] y_v;
    logic signed [31:0] d_new;
    logic signed [66:0] f_v;
    logic signed [66:0] s_v;
    logic signed [66:0] u_v;
    logic [28:0]        m_v;
    logic [29:0]        r2;
    logic [IDX_W-1:0]   idx;
    logic [Q_FRAC-1:0]  frac;
    logic signed [32:0] a1;
    logic signed [32:0] a2;
    logic signed [32:0] a3;

    assign status.inv = inv_reg;
    assign sample_out = out_reg;

    // stage coefficient and delay word
    always_comb
    begin
        case (cmd.stage)
            STG_HP:  coef = 33'(cfg.input_hp_coeff);
            STG_CAP: coef = 33'(cfg.cap_lp_coeff);
            default: coef = 33'(cfg.output_lp_coeff);
        endcase
        dly = dly_reg[cmd.stage][ch_reg];
    end

    // shared multiplier operands
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (cmd.op)
            OP_AP_M1:
            begin
                mul_a = coef;
                mul_b = 33'(x_reg);
            end
            OP_AP_M2:
            begin
                mul_a = coef;
                mul_b = 33'(y_reg);
            end
            OP_DRV_M:
            begin
                mul_a = 33'(x_reg);
                mul_b = $signed({9'd0, cfg.drive_gain});
            end
            OP_U_M:
            begin
                mul_a = 33'(s_reg);
                mul_b = cfg.diode_select ? SI_C : GE_C;
            end
            OP_INT_M:
            begin
                mul_a = diff_reg;
                mul_b = $signed({10'd0, frac});
            end
            OP_W_M1:
            begin
                mul_a = cfg.diode_select ? SI_K : GE_K;
                mul_b = 33'(a_reg);
            end
            OP_W_M2:
            begin
                mul_a = cfg.diode_select ? SI_R : GE_R;
                mul_b = 33'(s_reg);
            end
            OP_VOL_M:
            begin
                mul_a = 33'(x_reg);
                mul_b = $signed({9'd0, cfg.output_volume});
            end
            default: mul_en = 1'b0;
        endcase
    end

    // arithmetic around the registered product
    always_comb
    begin
        prod_rnd = rnd_shr(67'(prod_reg), 16);
        y_v      = prod_rnd + 67'(dly);
        d_new    = sat32(67'(x_reg) - prod_rnd);
        if (cmd.stage == STG_HP)
            f_v = rnd_shr(67'(x_reg) - 67'(y_reg), 1);
        else
            f_v = rnd_shr(67'(x_reg) + 67'(y_reg), 1);
        s_v = prod_rnd;
        if (s_v > 67'(CLIP_LIMIT))
            s_v = 67'(CLIP_LIMIT);
        if (s_v < -67'(CLIP_LIMIT))
            s_v = -67'(CLIP_LIMIT);
        u_v  = prod_rnd;
        m_v  = u_v[66] ? 29'(-u_v) : u_v[28:0];
        r2   = {rem_reg, nlo_reg[23]};
        idx  = t_reg[Q_FRAC -: IDX_W];
        frac = {t_reg[Q_FRAC-TAB_SHIFT-1:0], TAB_SHIFT'(0)};
        a1   = $signed({2'b00, lo_reg}) + 33'(prod_reg >>> Q_FRAC);
        a2   = inv_reg ? (HALF_PI_Q30 - a1) : a1;
        a3   = (a2 + 33'sd64) >>> 7;
    end

    // delay words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 3; s++)
                for (int c = 0; c < CHANNELS; c++)
                    dly_reg[s][c] <= '0;
        end
        else if (cmd.op == OP_AP_D)
            dly_reg[cmd.stage][ch_reg] <= d_new;
    end

    // flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg <= 1'b0;
            neg_reg <= 1'b0;
        end
        else if (cmd.op == OP_U)
        begin
            neg_reg <= u_v[66];
            inv_reg <= (m_v > ONE_Q23);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_LOAD:
            begin
                ch_reg <= (CHANNELS == 1) ? CH_W'(0) : CH_W'(channel_index);
                x_reg  <= 32'(sample_in);
            end
            OP_AP_Y:  y_reg <= sat32(y_v);
            OP_AP_D:  x_reg <= sat32(f_v);
            OP_DRV_S: s_reg <= s_v[26:0];
            OP_U:
            begin
                m_reg   <= m_v;
                t_reg   <= (m_v > ONE_Q23) ? 24'd0 : m_v[23:0];
                rem_reg <= 29'd4194304 + 29'(m_v[28:25]);
                nlo_reg <= m_v[24:1];
            end
            OP_DIV:
            begin
                // one quotient bit of 2^46 + m/2 over m
                if (inv_reg)
                begin
                    nlo_reg <= {nlo_reg[22:0], 1'b0};
                    if (r2 >= {1'b0, m_reg})
                    begin
                        rem_reg <= 29'(r2 - {1'b0, m_reg});
                        t_reg   <= {t_reg[22:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= r2[28:0];
                        t_reg   <= {t_reg[22:0], 1'b0};
                    end
                end
            end
            OP_TAB:
            begin
                if (idx >= IDX_W'(TAB_POINTS))
                begin
                    lo_reg   <= ATAN_TAB[TAB_POINTS];
                    diff_reg <= '0;
                end
                else
                begin
                    lo_reg   <= ATAN_TAB[idx];
                    diff_reg <= $signed({2'b00, ATAN_TAB[idx + IDX_W'(1)]})
                              - $signed({2'b00, ATAN_TAB[idx]});
                end
            end
            OP_INT:   a_reg   <= neg_reg ? 26'(-a3) : 26'(a3);
            OP_W_M2:  acc_reg <= prod_reg;
            OP_W:     x_reg   <= sat32(rnd_shr(67'(acc_reg) + 67'(prod_reg), 16));
            OP_OUT:   out_reg <= sat24(prod_rnd);
            default:  ;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/diode_clipper_distortion_chain.sv -----
// Diode clipper distortion chain. Each request carries one Q1.23 sample and its
// channel; one saturated Q1.23 sample comes back per request, in order. Work runs
// on one request at a time through a single shared 33x33 multiplier. Extra steps
// run for the capacitor low-pass stage when enabled, and a division runs when the
// scaled clipper signal exceeds 1.0 in magnitude (the reciprocal for the atan
// fold is found one quotient bit per cycle). A finished sample waits in an
// output register, so the next request is taken while it is pending. Registers
// are written over the APB port at 4*index and must be changed only while idle.
`default_nettype none

module diode_clipper_distortion_chain #(
    parameter int CHANNELS = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    dcd_in_if.sink           din,
    dcd_out_if.source        dout,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import dcd_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;
    logic    wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_hp_coeff  <= '0;
            cfg_reg.cap_lp_coeff    <= '0;
            cfg_reg.output_lp_coeff <= '0;
            cfg_reg.drive_gain      <= 24'd65536;
            cfg_reg.output_volume   <= 24'd65536;
            cfg_reg.cap_enable      <= 1'b0;
            cfg_reg.diode_select    <= 1'b1;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_INPUT_HP_COEFF:  cfg_reg.input_hp_coeff  <= pwdata[17:0];
                REG_CAP_LP_COEFF:    cfg_reg.cap_lp_coeff    <= pwdata[17:0];
                REG_OUTPUT_LP_COEFF: cfg_reg.output_lp_coeff <= pwdata[17:0];
                REG_DRIVE_GAIN:      cfg_reg.drive_gain      <= pwdata[23:0];
                REG_OUTPUT_VOLUME:   cfg_reg.output_volume   <= pwdata[23:0];
                REG_CAP_ENABLE:      cfg_reg.cap_enable      <= pwdata[0];
                REG_DIODE_SELECT:    cfg_reg.diode_select    <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        case (reg_idx)
            REG_INPUT_HP_COEFF:  prdata = {14'd0, cfg_reg.input_hp_coeff};
            REG_CAP_LP_COEFF:    prdata = {14'd0, cfg_reg.cap_lp_coeff};
            REG_OUTPUT_LP_COEFF: prdata = {14'd0, cfg_reg.output_lp_coeff};
            REG_DRIVE_GAIN:      prdata = {8'd0, cfg_reg.drive_gain};
            REG_OUTPUT_VOLUME:   prdata = {8'd0, cfg_reg.output_volume};
            REG_CAP_ENABLE:      prdata = {31'd0, cfg_reg.cap_enable};
            REG_DIODE_SELECT:    prdata = {31'd0, cfg_reg.diode_select};
            default:             prdata = '0;
        endcase
    end

    dcd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (din.valid),
        .in_ready   (din.ready),
        .out_valid  (dout.valid),
        .out_ready  (dout.ready),
        .cap_enable (cfg_reg.cap_enable),
        .status     (status),
        .cmd        (cmd)
    );

    dcd_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg           (cfg_reg),
        .channel_index (din.channel_index),
        .sample_in     (din.sample_in),
        .status        (status),
        .sample_out    (dout.sample_out)
    );

endmodule

`default_nettype wire

// ----- rtl/dcd_checker.sv -----
`default_nettype none

module dcd_sva (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [23:0] sample_out
);

    // hold a pending result until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // hold result data while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(sample_out))
        else $error("result changed while stalled");

    // one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    // no result appears right after a request
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result too early");

endmodule

bind diode_clipper_distortion_chain dcd_sva u_dcd_sva (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (din.valid),
    .in_ready   (din.ready),
    .out_valid  (dout.valid),
    .out_ready  (dout.ready),
    .sample_out (dout.sample_out)
);

`default_nettype wire
